// File: rtl/ppdsm_pkg.sv
package ppdsm_pkg;

    localparam logic [31:0] SPEED_SCALE_RESET = 32'd8000000;
    localparam logic [16:0] DUTY_ONE          = 17'd65536;
    localparam logic [1:0]  PHASE_LAST        = 2'd3;
    localparam int          STEP_COUNT_WIDTH  = 6;
    localparam logic [STEP_COUNT_WIDTH-1:0] DUTY_STEPS  = 6'd16;
    localparam logic [STEP_COUNT_WIDTH-1:0] SPEED_STEPS = 6'd32;

    typedef enum logic [2:0] {
        ST_RUN,
        ST_DIFF,
        ST_SUM,
        ST_CHECK,
        ST_DUTY,
        ST_LINK,
        ST_SPEED,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic do_diff;
        logic do_sum;
        logic duty_one;
        logic duty_take;
        logic load_duty;
        logic load_speed;
        logic div_step;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic capture_done;
        logic period_zero;
        logic pulse_ge;
        logic div_last;
    } status_t;

endpackage

// File: rtl/ppdsm_ctrl.sv
module ppdsm_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  ppdsm_pkg::status_t status,
    input  logic               m_ready,
    output logic               s_ready,
    output logic               m_valid,
    output ppdsm_pkg::cmd_t    cmd
);
    import ppdsm_pkg::*;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_RUN;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_RUN: begin
                if (status.capture_done) begin
                    state_next = ST_DIFF;
                end
            end
            ST_DIFF: begin
                cmd.do_diff = 1'b1;
                state_next  = ST_SUM;
            end
            ST_SUM: begin
                cmd.do_sum = 1'b1;
                state_next = ST_CHECK;
            end
            ST_CHECK: begin
                if (status.period_zero) begin
                    state_next = ST_OUT;
                end else if (status.pulse_ge) begin
                    // duty saturates, go straight to the speed division
                    cmd.duty_one   = 1'b1;
                    cmd.load_speed = 1'b1;
                    state_next     = ST_SPEED;
                end else begin
                    cmd.load_duty = 1'b1;
                    state_next    = ST_DUTY;
                end
            end
            ST_DUTY: begin
                cmd.div_step = 1'b1;
                if (status.div_last) begin
                    state_next = ST_LINK;
                end
            end
            ST_LINK: begin
                cmd.duty_take  = 1'b1;
                cmd.load_speed = 1'b1;
                state_next     = ST_SPEED;
            end
            ST_SPEED: begin
                cmd.div_step = 1'b1;
                if (status.div_last) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!out_valid_reg || m_ready) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_RUN;
                end
            end
            default: begin
                state_next = ST_RUN;
            end
        endcase
    end

    always_comb begin
        if (cmd.load_out) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    assign s_ready = (state_reg == ST_RUN);
    assign m_valid = out_valid_reg;

endmodule

// File: rtl/ppdsm_datapath.sv
module ppdsm_datapath #(
    parameter int STAMP_WIDTH = 32
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_accept,
    input  logic               s_signal_level,
    input  logic               cfg_write,
    input  logic [31:0]        cfg_speed_scale,
    input  ppdsm_pkg::cmd_t    cmd,
    output ppdsm_pkg::status_t status,
    output logic [31:0]        m_period_ticks,
    output logic [31:0]        m_pulse_ticks,
    output logic [16:0]        m_duty_fraction,
    output logic [31:0]        m_shaft_speed,
    output logic               m_divide_fault
);
    import ppdsm_pkg::*;

    localparam int SW = STAMP_WIDTH;

    // capture side
    logic [SW-1:0] stamp_reg, stamp_next;
    logic          last_level_reg;
    logic [1:0]    phase_reg, phase_next;
    logic [SW-1:0] edge_reg [4];
    logic [31:0]   scale_reg;

    // arithmetic
    logic [SW-1:0] per_a_reg, per_b_reg, pul_a_reg, pul_b_reg;
    logic [SW-1:0] period_reg, pulse_reg;
    logic [SW:0]   per_sum, pul_sum;
    logic [SW-1:0] rem_reg, rem_next;
    logic [31:0]   num_reg, quo_reg;
    logic [STEP_COUNT_WIDTH-1:0] count_reg;
    logic [SW:0]   trial, trial_diff;
    logic          trial_ge;
    logic [16:0]   duty_reg;
    logic [63:0]   period_wide, pulse_wide;
    logic [31:0]   period_sat, pulse_sat;

    // result word
    logic [31:0] period_out_reg, pulse_out_reg, speed_out_reg;
    logic [16:0] duty_out_reg;
    logic        fault_out_reg;

    logic rising, falling, hit, last_hit;

    assign rising   = !last_level_reg && s_signal_level;
    assign falling  = last_level_reg && !s_signal_level;
    assign hit      = phase_reg[0] ? falling : rising;
    assign last_hit = hit && (phase_reg == PHASE_LAST);

    always_comb begin
        stamp_next = last_hit ? '0 : stamp_reg + 1'b1;
        phase_next = phase_reg;
        if (hit) begin
            phase_next = last_hit ? 2'd0 : phase_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stamp_reg      <= '0;
            last_level_reg <= 1'b0;
            phase_reg      <= '0;
            scale_reg      <= SPEED_SCALE_RESET;
        end else begin
            if (in_accept) begin
                stamp_reg      <= stamp_next;
                last_level_reg <= s_signal_level;
                phase_reg      <= phase_next;
            end
            if (cfg_write) begin
                scale_reg <= cfg_speed_scale;
            end
        end
    end

    // the stamp held before this word's increment
    always_ff @(posedge aclk) begin
        if (in_accept && hit) begin
            edge_reg[phase_reg] <= stamp_reg;
        end
    end

    assign per_sum = {1'b0, per_a_reg} + {1'b0, per_b_reg};
    assign pul_sum = {1'b0, pul_a_reg} + {1'b0, pul_b_reg};

    always_ff @(posedge aclk) begin
        if (cmd.do_diff) begin
            per_a_reg <= edge_reg[2] - edge_reg[0];
            per_b_reg <= edge_reg[3] - edge_reg[1];
            pul_a_reg <= edge_reg[1] - edge_reg[0];
            pul_b_reg <= edge_reg[3] - edge_reg[2];
        end
        if (cmd.do_sum) begin
            period_reg <= per_sum[SW:1];
            pulse_reg  <= pul_sum[SW:1];
        end
    end

    // shared restoring divider, one quotient bit a cycle, divisor is the period
    assign trial      = {rem_reg, num_reg[31]};
    assign trial_diff = trial - {1'b0, period_reg};
    assign trial_ge   = (trial >= {1'b0, period_reg});
    assign rem_next   = trial_ge ? trial_diff[SW-1:0] : trial[SW-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (cmd.load_duty) begin
            count_reg <= DUTY_STEPS;
        end else if (cmd.load_speed) begin
            count_reg <= SPEED_STEPS;
        end else if (cmd.div_step) begin
            count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_duty) begin
            rem_reg <= pulse_reg;
            num_reg <= '0;
            quo_reg <= '0;
        end else if (cmd.load_speed) begin
            rem_reg <= '0;
            num_reg <= scale_reg;
            quo_reg <= '0;
        end else if (cmd.div_step) begin
            rem_reg <= rem_next;
            num_reg <= {num_reg[30:0], 1'b0};
            quo_reg <= {quo_reg[30:0], trial_ge};
        end
        if (cmd.duty_one) begin
            duty_reg <= DUTY_ONE;
        end else if (cmd.duty_take) begin
            duty_reg <= {1'b0, quo_reg[15:0]};
        end
    end

    assign period_wide = 64'(period_reg);
    assign pulse_wide  = 64'(pulse_reg);
    assign period_sat  = (|period_wide[63:32]) ? 32'hFFFF_FFFF : period_wide[31:0];
    assign pulse_sat   = (|pulse_wide[63:32]) ? 32'hFFFF_FFFF : pulse_wide[31:0];

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            if (status.period_zero) begin
                period_out_reg <= '0;
                pulse_out_reg  <= '0;
                duty_out_reg   <= '0;
                speed_out_reg  <= '0;
                fault_out_reg  <= 1'b1;
            end else begin
                period_out_reg <= period_sat;
                pulse_out_reg  <= pulse_sat;
                duty_out_reg   <= duty_reg;
                speed_out_reg  <= quo_reg;
                fault_out_reg  <= 1'b0;
            end
        end
    end

    assign status.capture_done = in_accept && last_hit;
    assign status.period_zero  = (period_reg == '0);
    assign status.pulse_ge     = (pulse_reg >= period_reg);
    assign status.div_last     = (count_reg == 6'd1);

    assign m_period_ticks  = period_out_reg;
    assign m_pulse_ticks   = pulse_out_reg;
    assign m_duty_fraction = duty_out_reg;
    assign m_shaft_speed   = speed_out_reg;
    assign m_divide_fault  = fault_out_reg;

endmodule

// File: rtl/pulse_period_duty_speed_meter.sv
// Takes one signal_level word a cycle while capturing edges; the timestamp advances per word.
// After the word that completes the capture, input stalls: difference, sum and check, then a
// 16-bit duty quotient, a link step and a 32-bit speed quotient from the shared shift-subtract
// divider, the load and any m_ready wait; saturated duty skips to speed, zero period to load.
// Synchronous active-low reset clears timestamp, level, capture phase and handshake state;
// speed_scale returns to 8000000. Edge stamps are not reset.
module pulse_period_duty_speed_meter #(
    parameter int STAMP_WIDTH = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_signal_level,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_period_ticks,
    output logic [31:0] m_pulse_ticks,
    output logic [16:0] m_duty_fraction,
    output logic [31:0] m_shaft_speed,
    output logic        m_divide_fault,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_speed_scale
);
    import ppdsm_pkg::*;

    cmd_t    cmd;
    status_t status;
    logic    in_accept;

    assign in_accept = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    ppdsm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .status  (status),
        .m_ready (m_ready),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .cmd     (cmd)
    );

    ppdsm_datapath #(
        .STAMP_WIDTH (STAMP_WIDTH)
    ) u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .in_accept       (in_accept),
        .s_signal_level  (s_signal_level),
        .cfg_write       (cfg_valid),
        .cfg_speed_scale (cfg_speed_scale),
        .cmd             (cmd),
        .status          (status),
        .m_period_ticks  (m_period_ticks),
        .m_pulse_ticks   (m_pulse_ticks),
        .m_duty_fraction (m_duty_fraction),
        .m_shaft_speed   (m_shaft_speed),
        .m_divide_fault  (m_divide_fault)
    );

`ifndef SYNTHESIS
    // a faulted word carries zeros everywhere else
    a_fault_zeros: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_divide_fault) |-> (m_period_ticks == '0 && m_pulse_ticks == '0
            && m_duty_fraction == '0 && m_shaft_speed == '0))
        else $error("fault word with nonzero fields");

    a_duty_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_duty_fraction <= DUTY_ONE))
        else $error("duty above one");

    a_period_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_divide_fault) |-> (m_period_ticks != '0))
        else $error("zero period without fault");

    // after the capture completes no input is taken until the result is loaded
    a_stall_after_capture: assert property (@(posedge aclk) disable iff (!aresetn)
        status.capture_done |=> !s_ready)
        else $error("input taken during computation");
`endif

endmodule
